// ===== design/sdp_pkg.sv =====
// ---------------------------------------------------------------------------
// sdp_pkg: shared types and constants of the stereo dynamics processor
// Controller states, datapath operation codes, command/status bundles and
// register reset values.
// ---------------------------------------------------------------------------
package sdp_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_THR     = 3'd1;
  localparam logic [2:0] REG_SLOPE   = 3'd2;
  localparam logic [2:0] REG_ATTACK  = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_CEIL    = 3'd5;
  localparam logic [2:0] REG_HOLD    = 3'd6;
  localparam logic [2:0] REG_MIX     = 3'd7;

  // operating modes
  localparam logic [1:0] MODE_COMP  = 2'd0;
  localparam logic [1:0] MODE_LIM   = 2'd1;
  localparam logic [1:0] MODE_GATE  = 2'd2;
  localparam logic [1:0] MODE_THRU  = 2'd3;

  // reset values
  localparam logic [31:0] THR_RST     = 32'd529290;
  localparam logic [15:0] SLOPE_RST   = 16'd49152;
  localparam logic [15:0] ATTACK_RST  = 16'd136;
  localparam logic [15:0] RELEASE_RST = 16'd14;
  localparam logic [31:0] CEIL_RST    = 32'd7919353;
  localparam logic [16:0] HOLD_RST    = 17'd960;
  localparam logic [16:0] MIX_RST     = 17'd65536;
  localparam logic [16:0] MIX_FULL    = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PEAK, ST_DECIDE, ST_LOGP, ST_LOGT, ST_EXPM, ST_EXPG, ST_DIV,
    ST_SMUL, ST_SADD, ST_AMUL, ST_AWET, ST_MMUL, ST_MSUM, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PEAK, OP_LOGP_INIT, OP_NORM, OP_LOGT_INIT,
    OP_LOGDIFF, OP_EXPMUL, OP_EXPGAIN, OP_DIV_INIT, OP_DIV, OP_TGT_QUOT,
    OP_TGT_UNITY, OP_GATE, OP_SMUL, OP_SADD, OP_AMUL, OP_AWET, OP_MMUL,
    OP_MSUM, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   ch;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       peak_gt;
    logic       peak_ge;
    logic       hold_nz;
    logic       norm_done;
    logic       div_done;
  } sts_t;

endpackage

// ===== design/stereo_dynamics_processor_unit.sv =====
// ---------------------------------------------------------------------------
// stereo_dynamics_processor_unit: stereo compressor / limiter / noise gate
// Stereo-linked dynamics stage with dry/wet mix on stream channels.
// ---------------------------------------------------------------------------
// Input: one transfer on s_axis carries a left/right sample pair; output:
// one transfer on m_axis carries the processed pair. The block handles one
// pair at a time. The path from acceptance to the result on m_axis is
// shortest in the open or holding gate and in pass-through mode, which skip
// the smoother; the compressor and limiter below threshold and the decaying
// gate add the smoother, the limiter above threshold also the divider (one
// quotient bit a cycle, then a step to take the quotient), the compressor
// above threshold also the log2 normaliser (one bit shifted a cycle, for
// peak and threshold in turn) and the exp2 gain. The next pair is accepted
// in the cycle after the result is registered. s_axis_tready is high only
// while the sequencer is idle. The result sits in an output register, so
// the next pair is accepted while it waits; if the receiver stalls, the
// following result is held in the datapath until the register frees up.
// Configuration writes take effect at the clock edge where cfg_we_i is high
// and belong in idle periods; writing a new mode resets the gain envelope
// and gate hold counter. Reset restores the control registers and state.
// ---------------------------------------------------------------------------
module stereo_dynamics_processor_unit #(
  parameter  int SAMPLE_BITS = 24,
  localparam int CFG_W = (SAMPLE_BITS - 1 > 17) ? SAMPLE_BITS - 1 : 17,
  localparam int TDW   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [TDW-1:0]   s_axis_tdata,  // left_sample, right_sample
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [TDW-1:0]   m_axis_tdata,  // left_out, right_out
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int SB = SAMPLE_BITS;

  sdp_pkg::cmd_t cmd;
  sdp_pkg::sts_t sts;

  logic [1:0]    mode, mode_new;
  logic          mode_chg;
  logic [SB-2:0] thr, ceil_lvl;
  logic [15:0]   slope, attack, release_s;
  logic [16:0]   hold, mix;
  logic signed [SB-1:0] left_out, right_out;

  sdp_cfg #(.SB(SB), .CW(CFG_W)) u_cfg (
    .clk_i, .rst_ni,
    .we_i      (cfg_we_i),
    .idx_i     (cfg_addr_i),
    .wdata_i   (cfg_wdata_i),
    .mode_o    (mode),
    .thr_o     (thr),
    .slope_o   (slope),
    .attack_o  (attack),
    .release_o (release_s),
    .ceil_o    (ceil_lvl),
    .hold_o    (hold),
    .mix_o     (mix),
    .mode_chg_o(mode_chg),
    .mode_new_o(mode_new)
  );

  sdp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdp_dpath #(.SB(SB)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .sts_o     (sts),
    .left_i    ($signed(s_axis_tdata[SB-1:0])),
    .right_i   ($signed(s_axis_tdata[2*SB-1:SB])),
    .mode_i    (mode),
    .thr_i     (thr),
    .slope_i   (slope),
    .attack_i  (attack),
    .release_i (release_s),
    .ceil_i    (ceil_lvl),
    .hold_i    (hold),
    .mix_i     (mix),
    .mode_chg_i(mode_chg),
    .mode_new_i(mode_new),
    .left_o    (left_out),
    .right_o   (right_out)
  );

  assign m_axis_tdata = TDW'({right_out, left_out});

endmodule

// ===== design/sdp_cfg.sv =====
// ---------------------------------------------------------------------------
// sdp_cfg: configuration register file
// Holds the eight control registers and flags a change of mode.
// ---------------------------------------------------------------------------
module sdp_cfg #(
  parameter int SB   = 24,
  parameter int CW   = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [2:0]    idx_i,
  input  logic [CW-1:0] wdata_i,
  output logic [1:0]    mode_o,
  output logic [SB-2:0] thr_o,
  output logic [15:0]   slope_o,
  output logic [15:0]   attack_o,
  output logic [15:0]   release_o,
  output logic [SB-2:0] ceil_o,
  output logic [16:0]   hold_o,
  output logic [16:0]   mix_o,
  output logic          mode_chg_o,
  output logic [1:0]    mode_new_o
);

  localparam int F = SB - 1;

  logic [1:0]   mode_q;
  logic [F-1:0] thr_q, ceil_q;
  logic [15:0]  slope_q, attack_q, release_q;
  logic [16:0]  hold_q, mix_q;

  assign mode_new_o = wdata_i[1:0];
  assign mode_chg_o = we_i && (idx_i == sdp_pkg::REG_MODE) && (wdata_i[1:0] != mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sdp_pkg::MODE_COMP;
      thr_q     <= sdp_pkg::THR_RST[F-1:0];
      slope_q   <= sdp_pkg::SLOPE_RST;
      attack_q  <= sdp_pkg::ATTACK_RST;
      release_q <= sdp_pkg::RELEASE_RST;
      ceil_q    <= sdp_pkg::CEIL_RST[F-1:0];
      hold_q    <= sdp_pkg::HOLD_RST;
      mix_q     <= sdp_pkg::MIX_RST;
    end else if (we_i) begin
      case (idx_i)
        sdp_pkg::REG_MODE:    mode_q    <= wdata_i[1:0];
        sdp_pkg::REG_THR:     thr_q     <= wdata_i[F-1:0];
        sdp_pkg::REG_SLOPE:   slope_q   <= wdata_i[15:0];
        sdp_pkg::REG_ATTACK:  attack_q  <= wdata_i[15:0];
        sdp_pkg::REG_RELEASE: release_q <= wdata_i[15:0];
        sdp_pkg::REG_CEIL:    ceil_q    <= wdata_i[F-1:0];
        sdp_pkg::REG_HOLD:    hold_q    <= wdata_i[16:0];
        sdp_pkg::REG_MIX:     mix_q     <= wdata_i[16:0];
        default: ;
      endcase
    end
  end

  assign mode_o    = mode_q;
  assign thr_o     = thr_q;
  assign slope_o   = slope_q;
  assign attack_o  = attack_q;
  assign release_o = release_q;
  assign ceil_o    = ceil_q;
  assign hold_o    = hold_q;
  assign mix_o     = mix_q;

endmodule

// ===== design/sdp_ctrl.sv =====
// ---------------------------------------------------------------------------
// sdp_ctrl: sequencing controller
// Steps the datapath through detection, gain computation, smoothing and the
// per-channel gain and mix, and owns the output valid flag.
// ---------------------------------------------------------------------------
module sdp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sdp_pkg::sts_t sts_i,
  output sdp_pkg::cmd_t cmd_o
);

  sdp_pkg::state_e state_q, state_d;
  logic            ch_q, ch_d;
  logic            ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdp_pkg::ST_IDLE;
      ch_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    ov_d      = ov_q && !out_ready_i;
    cmd_o.op  = sdp_pkg::OP_NONE;
    cmd_o.ch  = ch_q;
    case (state_q)
      sdp_pkg::ST_IDLE: begin
        ch_d = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = sdp_pkg::OP_LOAD;
          state_d  = sdp_pkg::ST_PEAK;
        end
      end
      sdp_pkg::ST_PEAK: begin
        cmd_o.op = sdp_pkg::OP_PEAK;
        state_d  = sdp_pkg::ST_DECIDE;
      end
      sdp_pkg::ST_DECIDE: begin
        case (sts_i.mode)
          sdp_pkg::MODE_COMP: begin
            cmd_o.op = sts_i.peak_gt ? sdp_pkg::OP_LOGP_INIT : sdp_pkg::OP_TGT_UNITY;
            state_d  = sts_i.peak_gt ? sdp_pkg::ST_LOGP : sdp_pkg::ST_SMUL;
          end
          sdp_pkg::MODE_LIM: begin
            cmd_o.op = sts_i.peak_gt ? sdp_pkg::OP_DIV_INIT : sdp_pkg::OP_TGT_UNITY;
            state_d  = sts_i.peak_gt ? sdp_pkg::ST_DIV : sdp_pkg::ST_SMUL;
          end
          sdp_pkg::MODE_GATE: begin
            cmd_o.op = sdp_pkg::OP_GATE;
            state_d  = (sts_i.peak_ge || sts_i.hold_nz) ? sdp_pkg::ST_AMUL
                                                         : sdp_pkg::ST_SMUL;
          end
          default: state_d = sdp_pkg::ST_AMUL;
        endcase
      end
      sdp_pkg::ST_LOGP: begin
        if (sts_i.norm_done) begin
          cmd_o.op = sdp_pkg::OP_LOGT_INIT;
          state_d  = sdp_pkg::ST_LOGT;
        end else begin
          cmd_o.op = sdp_pkg::OP_NORM;
        end
      end
      sdp_pkg::ST_LOGT: begin
        if (sts_i.norm_done) begin
          cmd_o.op = sdp_pkg::OP_LOGDIFF;
          state_d  = sdp_pkg::ST_EXPM;
        end else begin
          cmd_o.op = sdp_pkg::OP_NORM;
        end
      end
      sdp_pkg::ST_EXPM: begin
        cmd_o.op = sdp_pkg::OP_EXPMUL;
        state_d  = sdp_pkg::ST_EXPG;
      end
      sdp_pkg::ST_EXPG: begin
        cmd_o.op = sdp_pkg::OP_EXPGAIN;
        state_d  = sdp_pkg::ST_SMUL;
      end
      sdp_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.op = sdp_pkg::OP_TGT_QUOT;
          state_d  = sdp_pkg::ST_SMUL;
        end else begin
          cmd_o.op = sdp_pkg::OP_DIV;
        end
      end
      sdp_pkg::ST_SMUL: begin
        cmd_o.op = sdp_pkg::OP_SMUL;
        state_d  = sdp_pkg::ST_SADD;
      end
      sdp_pkg::ST_SADD: begin
        cmd_o.op = sdp_pkg::OP_SADD;
        state_d  = sdp_pkg::ST_AMUL;
      end
      sdp_pkg::ST_AMUL: begin
        cmd_o.op = sdp_pkg::OP_AMUL;
        state_d  = sdp_pkg::ST_AWET;
      end
      sdp_pkg::ST_AWET: begin
        cmd_o.op = sdp_pkg::OP_AWET;
        state_d  = sdp_pkg::ST_MMUL;
      end
      sdp_pkg::ST_MMUL: begin
        cmd_o.op = sdp_pkg::OP_MMUL;
        state_d  = sdp_pkg::ST_MSUM;
      end
      sdp_pkg::ST_MSUM: begin
        cmd_o.op = sdp_pkg::OP_MSUM;
        ch_d     = !ch_q;
        state_d  = ch_q ? sdp_pkg::ST_DONE : sdp_pkg::ST_AMUL;
      end
      sdp_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          cmd_o.op = sdp_pkg::OP_OUT;
          ov_d     = 1'b1;
          state_d  = sdp_pkg::ST_IDLE;
        end
      end
      default: state_d = sdp_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == sdp_pkg::ST_IDLE);
  assign out_valid_o = ov_q;

endmodule

// ===== design/sdp_dpath.sv =====
// ---------------------------------------------------------------------------
// sdp_dpath: gain datapath
// Peak detector, log2 normaliser, exp2 gain, restoring divider, envelope
// smoother, gain/clamp stage, dry/wet mixer and the output register.
// ---------------------------------------------------------------------------
module sdp_dpath #(
  parameter int SB = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdp_pkg::cmd_t        cmd_i,
  output sdp_pkg::sts_t        sts_o,
  input  logic signed [SB-1:0] left_i,
  input  logic signed [SB-1:0] right_i,
  input  logic [1:0]           mode_i,
  input  logic [SB-2:0]        thr_i,
  input  logic [15:0]          slope_i,
  input  logic [15:0]          attack_i,
  input  logic [15:0]          release_i,
  input  logic [SB-2:0]        ceil_i,
  input  logic [16:0]          hold_i,
  input  logic [16:0]          mix_i,
  input  logic                 mode_chg_i,
  input  logic [1:0]           mode_new_i,
  output logic signed [SB-1:0] left_o,
  output logic signed [SB-1:0] right_o
);

  localparam int F  = SB - 1;
  localparam int DW = $clog2(SB);
  localparam logic [SB-1:0] UNITY = SB'(1) << F;

  logic signed [SB-1:0] dry_q [2];
  logic signed [SB-1:0] res_q [2];
  logic signed [SB-1:0] out_q [2];
  logic [SB-1:0]        peak_q, tgt_q, env_q, sm_q, rem_q;
  logic [F-1:0]         quo_q;
  logic [DW-1:0]        dcnt_q;
  logic [31:0]          nx_q;
  logic [4:0]           ne_q;
  logic [20:0]          lp_q, d_q, em_q;
  logic [16:0]          hold_q;
  logic [2*SB-1:0]      prod_q;
  logic signed [SB:0]   wy_q;
  logic signed [SB+17:0] p1_q;
  logic signed [SB+18:0] p2_q;

  // detector
  logic [SB-1:0] thr_x, mag0, mag1, magc;
  logic signed [SB-1:0] dryc;
  assign thr_x = {1'b0, thr_i};
  assign mag0  = dry_q[0][SB-1] ? (~dry_q[0] + 1'b1) : dry_q[0];
  assign mag1  = dry_q[1][SB-1] ? (~dry_q[1] + 1'b1) : dry_q[1];
  assign dryc  = dry_q[cmd_i.ch];
  assign magc  = dryc[SB-1] ? (~dryc + 1'b1) : dryc;

  // log2 normaliser
  logic        norm_done;
  logic [20:0] log_cur;
  assign norm_done = nx_q[31] || (ne_q == 5'd0);
  assign log_cur   = {ne_q, nx_q[30:15]};

  // exp2 of the attenuation
  logic [21:0]    msum;
  logic [5:0]     n_sh;
  logic [15:0]    r_fr;
  logic [F+15:0]  r_x;
  logic [SB-1:0]  mant, egain;
  assign msum  = {1'b0, em_q} + 22'd65535;
  assign n_sh  = msum[21:16];
  assign r_fr  = ~em_q[15:0] + 16'd1;
  assign r_x   = (F+16)'(r_fr) << F;
  assign mant  = {1'b1, r_x[F+15:16]};
  assign egain = (n_sh >= 6'd63) ? '0 : (mant >> n_sh);

  // divider step
  logic [SB-1:0] dtry;
  logic          dge;
  assign dtry = {rem_q[SB-2:0], 1'b0};
  assign dge  = dtry >= peak_q;

  // smoother
  logic          tge;
  logic [SB-1:0] sdiff;
  logic [15:0]   sstep;
  logic [SB+15:0] sprod;
  assign tge   = tgt_q >= env_q;
  assign sdiff = tge ? (tgt_q - env_q) : (env_q - tgt_q);
  assign sstep = (mode_i == sdp_pkg::MODE_COMP && !tge) ? attack_i : release_i;
  assign sprod = sstep * sdiff;

  // gain and clamp
  logic [SB-1:0]      ym;
  logic signed [SB:0] yv, cl, ywet;
  assign ym = prod_q[F+SB-1:F];
  assign yv = dryc[SB-1] ? -$signed({1'b0, ym}) : $signed({1'b0, ym});
  assign cl = $signed({2'b00, ceil_i});
  always_comb begin
    ywet = yv;
    if (mode_i == sdp_pkg::MODE_THRU) begin
      ywet = (SB+1)'(dryc);
    end else if (mode_i == sdp_pkg::MODE_LIM) begin
      if (yv > cl)       ywet = cl;
      else if (yv < -cl) ywet = -cl;
    end
  end

  // mixer
  logic [16:0]           mix_s, inv;
  logic signed [SB+19:0] msig;
  logic [SB+19:0]        mmag;
  logic [SB+19:0]        mq;
  logic signed [SB+19:0] mo;
  assign mix_s = (mix_i > sdp_pkg::MIX_FULL) ? sdp_pkg::MIX_FULL : mix_i;
  assign inv   = sdp_pkg::MIX_FULL - mix_s;
  assign msig  = (SB+20)'(p1_q) + (SB+20)'(p2_q);
  assign mmag  = msig[SB+19] ? (~msig + 1'b1) : msig;
  assign mq    = mmag >> 16;
  assign mo    = msig[SB+19] ? -$signed(mq) : $signed(mq);

  // state: envelope and hold counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q  <= '0;
      hold_q <= '0;
    end else if (mode_chg_i) begin
      env_q  <= (mode_new_i == sdp_pkg::MODE_COMP) ? '0 : UNITY;
      hold_q <= '0;
    end else begin
      case (cmd_i.op)
        sdp_pkg::OP_GATE: begin
          if (peak_q >= thr_x) begin
            env_q  <= UNITY;
            hold_q <= hold_i;
          end else if (hold_q != 17'd0) begin
            hold_q <= hold_q - 17'd1;
          end
        end
        sdp_pkg::OP_SADD: begin
          if (mode_i == sdp_pkg::MODE_LIM && !tge) env_q <= tgt_q;
          else if (tge)                           env_q <= env_q + sm_q;
          else                                    env_q <= env_q - sm_q;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sdp_pkg::OP_LOAD: begin
        dry_q[0] <= left_i;
        dry_q[1] <= right_i;
      end
      sdp_pkg::OP_PEAK: peak_q <= (mag0 > mag1) ? mag0 : mag1;
      sdp_pkg::OP_LOGP_INIT: begin
        nx_q <= (peak_q == '0) ? 32'd1 : 32'(peak_q);
        ne_q <= 5'd31;
      end
      sdp_pkg::OP_NORM: begin
        nx_q <= {nx_q[30:0], 1'b0};
        ne_q <= ne_q - 5'd1;
      end
      sdp_pkg::OP_LOGT_INIT: begin
        lp_q <= log_cur;
        nx_q <= (thr_x == '0) ? 32'd1 : 32'(thr_x);
        ne_q <= 5'd31;
      end
      sdp_pkg::OP_LOGDIFF: d_q <= (lp_q < log_cur) ? 21'd0 : (lp_q - log_cur);
      sdp_pkg::OP_EXPMUL: em_q <= 21'((37'(d_q) * 37'(slope_i)) >> 16);
      sdp_pkg::OP_EXPGAIN: tgt_q <= egain;
      sdp_pkg::OP_DIV_INIT: begin
        rem_q  <= thr_x;
        quo_q  <= '0;
        dcnt_q <= DW'(F);
      end
      sdp_pkg::OP_DIV: begin
        rem_q  <= dge ? (dtry - peak_q) : dtry;
        quo_q  <= {quo_q[F-2:0], dge};
        dcnt_q <= dcnt_q - 1'b1;
      end
      sdp_pkg::OP_TGT_QUOT: tgt_q <= {1'b0, quo_q};
      sdp_pkg::OP_TGT_UNITY: tgt_q <= UNITY;
      sdp_pkg::OP_GATE: tgt_q <= '0;
      sdp_pkg::OP_SMUL: sm_q <= sprod[SB+15:16];
      sdp_pkg::OP_AMUL: prod_q <= magc * env_q;
      sdp_pkg::OP_AWET: wy_q <= ywet;
      sdp_pkg::OP_MMUL: begin
        p1_q <= dryc * $signed({1'b0, inv});
        p2_q <= wy_q * $signed({1'b0, mix_s});
      end
      sdp_pkg::OP_MSUM: res_q[cmd_i.ch] <= mo[SB-1:0];
      sdp_pkg::OP_OUT: begin
        out_q[0] <= res_q[0];
        out_q[1] <= res_q[1];
      end
      default: ;
    endcase
  end

  assign sts_o.mode      = mode_i;
  assign sts_o.peak_gt   = peak_q > thr_x;
  assign sts_o.peak_ge   = peak_q >= thr_x;
  assign sts_o.hold_nz   = hold_q != 17'd0;
  assign sts_o.norm_done = norm_done;
  assign sts_o.div_done  = dcnt_q == '0;

  assign left_o  = out_q[0];
  assign right_o = out_q[1];

endmodule
